FILE: hdl/bdr_pkg.sv
// Shared types, constants and reset values for the brace depth re-indenter.
package bdr_pkg;

  localparam int DEPTH_W       = 4;
  localparam int CNT_W         = 6;
  localparam int IW_W          = 3;
  localparam int ADDR_W        = 3;
  localparam int DATA_W        = 32;
  localparam int MAX_DEPTH_DEF = 15;
  localparam int QDEPTH_DEF    = 2;

  localparam logic [IW_W-1:0] IW_RESET = 3'd4;
  localparam logic [IW_W-1:0] IW_CAP   = 3'd4;

  localparam logic [ADDR_W-3:0] REG_INDENT = '0;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       text_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_end;
  } out_item_t;

  typedef struct packed {
    logic               en;
    logic [IW_W-1:0]    value;
  } cfg_wr_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic               line_start;
    logic               in_str;
    logic               in_chr;
    logic               in_lc;
    logic               in_bc;
    logic               esc;
    logic               slash;
    logic               star;
  } lex_state_t;

  localparam lex_state_t LEX_RESET = '{
    depth: '0, line_start: 1'b1, in_str: 1'b0, in_chr: 1'b0, in_lc: 1'b0,
    in_bc: 1'b0, esc: 1'b0, slash: 1'b0, star: 1'b0
  };

  typedef struct packed {
    logic [7:0]       data_byte;
    logic [CNT_W-1:0] spaces;
    logic             has_byte;
    logic             last;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SPACE,
    ST_BYTE,
    ST_TERM
  } bstate_t;

endpackage

FILE: hdl/bdr_if.sv
// Valid/ready stream interfaces for input bytes and result beats.
interface bdr_in_if ();
  import bdr_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bdr_out_if ();
  import bdr_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/bdr_front.sv
// Front end: lexical state tracking, indent count and command generation.
module bdr_front #(
  parameter int MAX_DEPTH = bdr_pkg::MAX_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  bdr_in_if.sink                in_ch,
  input  bdr_pkg::cfg_wr_t      cfg,
  output logic [bdr_pkg::IW_W-1:0] indent_width,
  input  logic                  q_full,
  output logic                  push,
  output bdr_pkg::cmd_t         cmd
);
  import bdr_pkg::*;

  lex_state_t         st;
  lex_state_t         st_next;
  logic               accept;
  logic               drop;
  logic [7:0]         b;
  logic [DEPTH_W-1:0] lv;
  logic [IW_W-1:0]    w;
  logic [DEPTH_W+IW_W-1:0] prod;
  logic               code_done;

  assign b            = in_ch.data.in_byte;
  assign in_ch.ready  = !q_full;
  assign accept       = in_ch.valid && in_ch.ready;
  assign w            = (indent_width > IW_CAP) ? IW_CAP : indent_width;

  always_comb begin
    st_next   = st;
    drop      = 1'b0;
    code_done = 1'b0;
    lv        = st.depth;
    if (st.line_start && !st.in_str && !st.in_bc && !st.in_chr &&
        b != CH_SPACE && b != CH_TAB && b == CH_RBRACE && st.depth != '0) begin
      lv = st.depth - 1'b1;
    end
    prod = {{IW_W{1'b0}}, lv} * {{DEPTH_W{1'b0}}, w};
    cmd.data_byte = b;
    cmd.last      = in_ch.data.text_last;
    cmd.spaces    = '0;
    if (st.line_start) begin
      if (!st.in_str && !st.in_bc && !st.in_chr) begin
        if (b == CH_SPACE || b == CH_TAB) begin
          drop = 1'b1;
        end else begin
          if (b != CH_LF && b != CH_CR) begin
            cmd.spaces = CNT_W'(prod);
          end
          st_next.line_start = 1'b0;
        end
      end else begin
        st_next.line_start = 1'b0;
      end
    end
    cmd.has_byte = !drop;

    if (!drop) begin
      if (st.esc) begin
        st_next.esc = 1'b0;
      end else begin
        if (st.in_lc) begin
          st_next.in_lc = st.in_lc;
        end else if (st.in_bc) begin
          if (st.star && b == CH_SLASH) begin
            st_next.in_bc = 1'b0;
            st_next.star  = 1'b0;
          end else begin
            st_next.star = (b == CH_STAR);
          end
        end else if (st.in_str) begin
          if (b == CH_BSLASH) begin
            st_next.esc = 1'b1;
          end else if (b == CH_DQUOTE) begin
            st_next.in_str = 1'b0;
          end
        end else if (st.in_chr) begin
          if (b == CH_BSLASH) begin
            st_next.esc = 1'b1;
          end else if (b == CH_SQUOTE) begin
            st_next.in_chr = 1'b0;
          end
        end else begin
          if (st.slash) begin
            st_next.slash = 1'b0;
            if (b == CH_SLASH) begin
              st_next.in_lc = 1'b1;
              code_done     = 1'b1;
            end else if (b == CH_STAR) begin
              st_next.in_bc = 1'b1;
              st_next.star  = 1'b0;
              code_done     = 1'b1;
            end
          end
          if (!code_done) begin
            if (b == CH_SLASH) begin
              st_next.slash = 1'b1;
            end else if (b == CH_DQUOTE) begin
              st_next.in_str = 1'b1;
            end else if (b == CH_SQUOTE) begin
              st_next.in_chr = 1'b1;
            end else if (b == CH_LBRACE) begin
              if (st.depth < DEPTH_W'(MAX_DEPTH)) begin
                st_next.depth = st.depth + 1'b1;
              end
            end else if (b == CH_RBRACE) begin
              if (st.depth != '0) begin
                st_next.depth = st.depth - 1'b1;
              end
            end
          end
        end
        if (b == CH_LF) begin
          st_next.line_start = 1'b1;
          st_next.in_lc      = 1'b0;
        end
      end
    end

    if (in_ch.data.text_last) begin
      st_next = LEX_RESET;
    end
  end

  assign push          = accept && (!drop || in_ch.data.text_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= LEX_RESET;
      indent_width <= IW_RESET;
    end else begin
      if (accept) begin
        st <= st_next;
      end
      if (accept && in_ch.data.text_last) begin
        indent_width <= IW_RESET;
      end else if (cfg.en) begin
        indent_width <= cfg.value;
      end
    end
  end

  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    accept && in_ch.data.text_last |=> st == LEX_RESET && indent_width == IW_RESET)
    else $error("state not restored after final byte");

  a_depth_cap: assert property (@(posedge clk) disable iff (rst)
    accept |=> st.depth <= DEPTH_W'(MAX_DEPTH))
    else $error("nesting depth beyond limit");

endmodule

FILE: hdl/bdr_fifo.sv
// Short command queue between front and back end.
module bdr_fifo #(
  parameter int DEPTH = bdr_pkg::QDEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bdr_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output bdr_pkg::cmd_t q_data
);
  import bdr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W_Q = $clog2(DEPTH + 1);

  cmd_t               entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W_Q-1:0] count;

  assign full    = (count == CNT_W_Q'(DEPTH));
  assign q_valid = (count != '0);
  assign q_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (full |-> !push) and (!q_valid |-> !pop))
    else $error("command queue overrun or underrun");

endmodule

FILE: hdl/bdr_back.sv
// Back end: plays out indent spaces, the copied byte and the terminator.
module bdr_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  bdr_pkg::cmd_t q_data,
  output logic          pop,
  bdr_out_if.source     out_ch
);
  import bdr_pkg::*;

  bstate_t          state;
  bstate_t          state_next;
  bstate_t          first_state;
  cmd_t             cur;
  logic [CNT_W-1:0] rem;
  logic             fire;
  logic             final_beat;

  assign fire       = out_ch.valid && out_ch.ready;
  assign final_beat = out_ch.data.run_last;
  assign pop        = q_valid && (state == ST_IDLE || (fire && final_beat));

  always_comb begin
    if (q_data.spaces != '0) begin
      first_state = ST_SPACE;
    end else if (q_data.has_byte) begin
      first_state = ST_BYTE;
    end else begin
      first_state = ST_TERM;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          state_next = first_state;
        end
      end
      ST_SPACE, ST_BYTE, ST_TERM: begin
        if (fire) begin
          if (final_beat) begin
            state_next = q_valid ? first_state : ST_IDLE;
          end else if (state == ST_SPACE) begin
            if (rem == CNT_W'(1)) begin
              state_next = cur.has_byte ? ST_BYTE : ST_TERM;
            end
          end else begin
            state_next = ST_TERM;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    out_ch.valid         = 1'b1;
    out_ch.data.out_byte = CH_NUL;
    out_ch.data.run_last = 1'b0;
    out_ch.data.text_end = 1'b0;
    case (state)
      ST_IDLE: begin
        out_ch.valid = 1'b0;
      end
      ST_SPACE: begin
        out_ch.data.out_byte = CH_SPACE;
        out_ch.data.run_last = (rem == CNT_W'(1)) && !cur.has_byte && !cur.last;
      end
      ST_BYTE: begin
        out_ch.data.out_byte = cur.data_byte;
        out_ch.data.run_last = !cur.last;
      end
      ST_TERM: begin
        out_ch.data.run_last = 1'b1;
        out_ch.data.text_end = 1'b1;
      end
      default: begin
        out_ch.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_data;
      rem <= q_data.spaces;
    end else if (fire && state == ST_SPACE) begin
      rem <= rem - 1'b1;
    end
  end

  a_space_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_SPACE |-> rem != '0)
    else $error("space run with empty count");

endmodule

FILE: hdl/brace_depth_reindenter.sv
// Top level of the brace depth re-indenter: APB register, front, queue and back.
// An accepted byte is queued, then the back end pops it and registers its first state.
// Throughput: one result beat per cycle while text_out is ready; an item's results
// are its indent spaces, its copied byte and, on the final byte, a terminator.
// Input is taken while the two-entry command queue has room.
// Reset (rst, synchronous): lexer state cleared, depth 0, indent width 4, queue empty.
module brace_depth_reindenter #(
  parameter int MAX_DEPTH = bdr_pkg::MAX_DEPTH_DEF,
  parameter int QDEPTH    = bdr_pkg::QDEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  bdr_in_if.sink                     text_in,
  bdr_out_if.source                  text_out,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bdr_pkg::ADDR_W-1:0] paddr,
  input  logic [bdr_pkg::DATA_W-1:0] pwdata,
  output logic [bdr_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import bdr_pkg::*;

  cfg_wr_t         cfg;
  logic [IW_W-1:0] indent_width;
  logic            q_full;
  logic            push;
  cmd_t            cmd;
  logic            pop;
  logic            q_valid;
  cmd_t            q_data;
  logic            reg_hit;

  assign pready    = 1'b1;
  assign reg_hit   = (paddr[ADDR_W-1:2] == REG_INDENT);
  assign cfg.en    = psel && penable && pwrite && pready && reg_hit;
  assign cfg.value = pwdata[IW_W-1:0];
  assign prdata    = reg_hit ? {{(DATA_W-IW_W){1'b0}}, indent_width} : '0;

  bdr_front #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_ch        (text_in),
    .cfg          (cfg),
    .indent_width (indent_width),
    .q_full       (q_full),
    .push         (push),
    .cmd          (cmd)
  );

  bdr_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (cmd),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  bdr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .pop     (pop),
    .out_ch  (text_out)
  );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the brace depth re-indenter: stimulus, scoreboard and checks.
`timescale 1ns / 100ps

module tb_top;
  import bdr_pkg::*;

  class reindent_scoreboard;
    out_item_t awaited_beats[$];
    out_item_t cur_run[$];
    logic [IW_W-1:0] indent;
    int level;
    bit at_line_start;
    bit in_quote;
    bit in_char;
    bit in_line_cmt;
    bit in_block_cmt;
    bit escape;
    bit after_slash;
    bit after_star;
    int errors;

    function new();
      indent = IW_RESET;
      errors = 0;
      clear_lexer();
    endfunction

    function void clear_lexer();
      level = 0;
      at_line_start = 1'b1;
      in_quote = 1'b0;
      in_char = 1'b0;
      in_line_cmt = 1'b0;
      in_block_cmt = 1'b0;
      escape = 1'b0;
      after_slash = 1'b0;
      after_star = 1'b0;
    endfunction

    function void push_beat(logic [7:0] b);
      out_item_t beat;
      beat.out_byte = b;
      beat.run_last = 1'b0;
      beat.text_end = 1'b0;
      cur_run.push_back(beat);
    endfunction

    function void lex_byte(logic [7:0] b);
      if (escape) begin
        push_beat(b);
        escape = 1'b0;
        return;
      end
      if (in_line_cmt) begin
      end else if (in_block_cmt) begin
        if (after_star && b == CH_SLASH) begin
          push_beat(b);
          in_block_cmt = 1'b0;
          after_star = 1'b0;
          return;
        end
        after_star = (b == CH_STAR);
      end else if (in_quote) begin
        if (b == CH_BSLASH) escape = 1'b1;
        else if (b == CH_DQUOTE) in_quote = 1'b0;
      end else if (in_char) begin
        if (b == CH_BSLASH) escape = 1'b1;
        else if (b == CH_SQUOTE) in_char = 1'b0;
      end else begin
        if (after_slash) begin
          after_slash = 1'b0;
          if (b == CH_SLASH) begin
            in_line_cmt = 1'b1;
            push_beat(b);
            return;
          end
          if (b == CH_STAR) begin
            in_block_cmt = 1'b1;
            after_star = 1'b0;
            push_beat(b);
            return;
          end
        end
        if (b == CH_SLASH) begin
          after_slash = 1'b1;
        end else if (b == CH_DQUOTE) begin
          in_quote = 1'b1;
        end else if (b == CH_SQUOTE) begin
          in_char = 1'b1;
        end else if (b == CH_LBRACE) begin
          push_beat(b);
          if (level < MAX_DEPTH_DEF) level++;
          return;
        end else if (b == CH_RBRACE) begin
          push_beat(b);
          if (level > 0) level--;
          return;
        end
      end
      push_beat(b);
      if (b == CH_LF) begin
        at_line_start = 1'b1;
        in_line_cmt = 1'b0;
      end
    endfunction

    function void note_byte(in_item_t item);
      logic [7:0] b;
      bit drop;
      int lv;
      int w;
      b = item.in_byte;
      drop = 1'b0;
      cur_run.delete();
      if (at_line_start) begin
        if (!in_quote && !in_block_cmt && !in_char) begin
          if (b == CH_SPACE || b == CH_TAB) begin
            drop = 1'b1;
          end else begin
            if (b != CH_LF && b != CH_CR) begin
              lv = level;
              w = (indent > IW_CAP) ? IW_CAP : indent;
              if (b == CH_RBRACE && lv > 0) lv--;
              repeat (lv * w) push_beat(CH_SPACE);
            end
            at_line_start = 1'b0;
          end
        end else begin
          at_line_start = 1'b0;
        end
      end
      if (!drop) lex_byte(b);
      if (item.text_last) begin
        push_beat(CH_NUL);
        cur_run[cur_run.size() - 1].text_end = 1'b1;
        clear_lexer();
        indent = IW_RESET;
      end
      if (cur_run.size() > 0) cur_run[cur_run.size() - 1].run_last = 1'b1;
      foreach (cur_run[i]) awaited_beats.push_back(cur_run[i]);
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_beat(out_item_t got);
      out_item_t want;
      if (awaited_beats.size() == 0) begin
        report($sformatf("beat %02h with nothing awaited", got.out_byte));
      end else begin
        want = awaited_beats.pop_front();
        if (got.out_byte !== want.out_byte)
          report($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
        if (got.run_last !== want.run_last)
          report($sformatf("run_last %b, want %b", got.run_last, want.run_last));
        if (got.text_end !== want.text_end)
          report($sformatf("text_end %b, want %b", got.text_end, want.text_end));
      end
    endtask
  endclass

  localparam int TOTAL_ITEMS = 220;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD = 300;
  localparam logic [ADDR_W-1:0] INDENT_REG_ADDR = {REG_INDENT, 2'b00};
  localparam logic [ADDR_W-1:0] UNUSED_REG_ADDR = 3'd4;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  bdr_in_if in_if ();
  bdr_out_if out_if ();

  reindent_scoreboard sb = new();
  logic [7:0] text_buf[$];
  int sent = 0;
  bit steady = 1'b0;
  int hold_asks = 0;

  brace_depth_reindenter u_dut (
    .clk     (clk),
    .rst     (rst),
    .text_in (in_if),
    .text_out(out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  function int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function logic [7:0] letter();
    return 8'h61 + 8'($urandom_range(0, 25));
  endfunction

  function void add_lit_char();
    case ($urandom_range(0, 5))
      0: text_buf.push_back(CH_LBRACE);
      1: text_buf.push_back(CH_RBRACE);
      2: text_buf.push_back(CH_LF);
      3: begin
        text_buf.push_back(CH_BSLASH);
        text_buf.push_back($urandom_range(0, 1) ? CH_LF : 8'($urandom_range(0, 255)));
      end
      default: text_buf.push_back(letter());
    endcase
  endfunction

  function void add_token();
    case ($urandom_range(0, 11))
      0, 1: begin
        text_buf.push_back(CH_LF);
        repeat ($urandom_range(0, 3))
          text_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
      end
      2: repeat ($urandom_range(1, 5)) text_buf.push_back(letter());
      3: begin
        repeat ($urandom_range(0, 5) == 0 ? $urandom_range(12, 17) : $urandom_range(1, 3))
          text_buf.push_back(CH_LBRACE);
      end
      4: repeat ($urandom_range(1, 3)) text_buf.push_back(CH_RBRACE);
      5: begin
        text_buf.push_back(CH_DQUOTE);
        repeat ($urandom_range(0, 5)) add_lit_char();
        text_buf.push_back(CH_DQUOTE);
      end
      6: begin
        text_buf.push_back(CH_SQUOTE);
        if ($urandom_range(0, 1)) text_buf.push_back(CH_BSLASH);
        text_buf.push_back($urandom_range(0, 1) ? letter() : 8'($urandom_range(0, 255)));
        text_buf.push_back(CH_SQUOTE);
      end
      7: begin
        text_buf.push_back(CH_SLASH);
        text_buf.push_back(CH_SLASH);
        repeat ($urandom_range(0, 4)) add_lit_char();
        text_buf.push_back(CH_LF);
      end
      8: begin
        text_buf.push_back(CH_SLASH);
        text_buf.push_back(CH_STAR);
        repeat ($urandom_range(0, 6)) begin
          case ($urandom_range(0, 3))
            0: text_buf.push_back(CH_STAR);
            1: text_buf.push_back(CH_SLASH);
            2: add_lit_char();
            default: text_buf.push_back(letter());
          endcase
        end
        text_buf.push_back(CH_STAR);
        text_buf.push_back(CH_SLASH);
      end
      9: text_buf.push_back(8'($urandom_range(0, 255)));
      10: begin
        text_buf.push_back(CH_SLASH);
        text_buf.push_back(letter());
      end
      default: begin
        text_buf.push_back(CH_CR);
        text_buf.push_back(CH_LF);
      end
    endcase
  endfunction

  task write_reg(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == INDENT_REG_ADDR) sb.indent = data[IW_W-1:0];
  endtask

  task send_byte(in_item_t item);
    in_if.valid <= 1'b1;
    in_if.data <= item;
    do @(posedge clk); while (!in_if.ready);
    sb.note_byte(item);
    sent++;
  endtask

  task idle_gap();
    int n;
    n = (steady || $urandom_range(0, 99) < 55) ? 0 : idle_len();
    if (n > 0) begin
      in_if.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task send_text();
    in_item_t item;
    foreach (text_buf[i]) begin
      item.in_byte = text_buf[i];
      item.text_last = (i == text_buf.size() - 1);
      send_byte(item);
      idle_gap();
    end
  endtask

  task wait_drained();
    in_if.valid <= 1'b0;
    while (sb.awaited_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int stall;
    int hold_served;
    stall = 0;
    hold_served = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) sb.check_beat(out_if.data);
      if (hold_asks != hold_served) begin
        hold_served = hold_asks;
        stall = LONG_HOLD;
      end else if (stall == 0 && !steady && $urandom_range(0, 99) < 20) begin
        stall = idle_len();
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [IW_W-1:0] corner_widths[4];
    logic [DATA_W-1:0] wdata;
    int target;
    corner_widths = '{3'd0, 3'd1, 3'd4, 3'd7};
    in_if.valid <= 1'b0;
    in_if.data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(UNUSED_REG_ADDR, $urandom);
    write_reg(INDENT_REG_ADDR, {$urandom} & ~32'h7 | 32'd2);
    text_buf = '{CH_SPACE, CH_TAB, CH_RBRACE, CH_LBRACE, CH_LF, CH_DQUOTE, CH_LBRACE,
                 CH_BSLASH, CH_LF, CH_DQUOTE, CH_SQUOTE, CH_BSLASH, CH_SQUOTE, CH_SQUOTE,
                 CH_SLASH, CH_SLASH, CH_RBRACE, CH_LF, CH_RBRACE, CH_SLASH, CH_STAR, CH_STAR,
                 CH_SLASH, CH_NUL, 8'hFF, CH_LF, CH_CR, CH_LF, CH_SPACE};
    send_text();
    wait_drained();

    for (int t = 0; sent < TOTAL_ITEMS; t++) begin
      if (t < 4 || $urandom_range(0, 2) == 0) begin
        wait_drained();
        wdata = $urandom;
        wdata[IW_W-1:0] = (t < 4) ? corner_widths[t] : IW_W'($urandom_range(0, 7));
        write_reg(INDENT_REG_ADDR, wdata);
      end
      steady = (t % 4 == 2);
      text_buf.delete();
      if (t == 3) begin
        repeat (MAX_DEPTH_DEF + 2) text_buf.push_back(CH_LBRACE);
        text_buf.push_back(CH_LF);
        text_buf.push_back(letter());
      end
      target = $urandom_range(10, 45);
      while (text_buf.size() < target) add_token();
      if (t == 1) hold_asks++;
      send_text();
    end
    steady = 1'b0;
    wait_drained();

    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
